/* design/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Table geometry, request and result codes, and the microcode ROM that
// sequences insert, lookup and dump.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int AW       = $clog2(CAPACITY);

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 16;
    localparam int ST_W     = 3;
    localparam int POS_W    = 7;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = OP_W + KEY_W + VAL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ST_W + POS_W + KEY_W + VAL_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_LISTED    = 3'd5;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             kind;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Program steps. Fall-through order matters: a step that does not jump
    // continues with the next one.
    typedef enum logic [3:0] {
        S_IDLE       = 4'd0,
        S_SCAN       = 4'd1,
        S_RESOLVE    = 4'd2,
        S_SHIFT      = 4'd3,
        S_DRAIN      = 4'd4,
        S_WNEW       = 4'd5,
        S_EMIT_RES   = 4'd6,
        S_DUMP_CHK   = 4'd7,
        S_DUMP       = 4'd8,
        S_DUMP_END   = 4'd9,
        S_EMIT_EMPTY = 4'd10
    } step_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_SCAN_MORE,
        C_REPORT,
        C_SHIFT_MORE,
        C_EMPTY,
        C_DUMP_MORE
    } cond_t;

    typedef enum logic [2:0] {
        U_NONE,
        U_ACCEPT,
        U_SCAN,
        U_RESOLVE,
        U_SHIFT,
        U_WNEW,
        U_DUMP
    } uop_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_RES,
        EM_LIST,
        EM_EMPTY
    } emit_t;

    typedef struct packed {
        uop_t  uop;
        emit_t emit;
        cond_t cond;
        step_t target;
    } ctl_t;

    function automatic ctl_t ucode(step_t step);
        ctl_t w;
        unique case (step)
            S_IDLE:       w = '{U_ACCEPT,  EM_NONE,  C_DISPATCH,   S_IDLE};
            S_SCAN:       w = '{U_SCAN,    EM_NONE,  C_SCAN_MORE,  S_SCAN};
            S_RESOLVE:    w = '{U_RESOLVE, EM_NONE,  C_REPORT,     S_EMIT_RES};
            S_SHIFT:      w = '{U_SHIFT,   EM_NONE,  C_SHIFT_MORE, S_SHIFT};
            S_DRAIN:      w = '{U_NONE,    EM_NONE,  C_NEXT,       S_IDLE};
            S_WNEW:       w = '{U_WNEW,    EM_NONE,  C_NEXT,       S_IDLE};
            S_EMIT_RES:   w = '{U_NONE,    EM_RES,   C_ALWAYS,     S_IDLE};
            S_DUMP_CHK:   w = '{U_NONE,    EM_NONE,  C_EMPTY,      S_EMIT_EMPTY};
            S_DUMP:       w = '{U_DUMP,    EM_LIST,  C_DUMP_MORE,  S_DUMP};
            S_DUMP_END:   w = '{U_NONE,    EM_NONE,  C_ALWAYS,     S_IDLE};
            S_EMIT_EMPTY: w = '{U_NONE,    EM_EMPTY, C_ALWAYS,     S_IDLE};
            default:      w = '{U_NONE,    EM_NONE,  C_ALWAYS,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* design/sorted_key_table_insert_lookup_unit.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_insert_lookup_unit: sorted key table with insert/lookup/dump
// Requests arrive on the s_ stream and results leave on the m_ stream; the
// table keeps up to CAPACITY entries in ascending key order, under a microcode ROM.
// s_tdata = {opcode, part_number, part_value} from the low bits up, s_tuser
// carries part_kind; m_tdata = {status, position, key_out, value_out}, m_tuser
// carries kind_out and m_tlast marks the final result of a request.
// A lookup or a rejected insert scans the entries in order and then gives its
// result; the next request can be taken in the cycle after that result is emitted.
// A stored insert then moves every later entry up by one, one per cycle, writes
// the new entry and gives its result. Dump gives one result per entry, one per
// cycle while the receiver takes them; an empty table gives one result with
// status empty. The single memory read port serves the scan, the move and the
// dump. An unused opcode is consumed with no result.
// Reset empties the table and drops any pending result. When the receiver
// stalls, the held result stays on m_ and the sequencer waits at the step that
// wants to emit; a new request can still be taken while the last result of the
// previous one waits.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_lookup_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: opcode[1:0], part_number[33:2], part_value[49:34], zero fill
    input  logic [skt_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: part_kind
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: status[2:0], position[9:3], key_out[41:10], value_out[57:42],
    // zero fill
    output logic [skt_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: kind_out
    output logic                          m_tuser,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import skt_pkg::*;

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    // Sequencer
    step_t pc_reg, pc_next;
    ctl_t  ctl;

    // Request
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    logic             kind_reg;
    logic [VAL_W-1:0] value_reg;

    // Datapath
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] pos_reg;
    logic             chk_reg;
    logic             hit_reg;
    logic [ST_W-1:0]  status_reg;
    logic             pend_reg;
    logic [AW-1:0]    wr_addr_reg;
    entry_t           rd_reg;
    entry_t           entry_mem [CAPACITY];

    // Output register
    logic             m_tvalid_reg;
    logic [ST_W-1:0]  o_status_reg;
    logic [POS_W-1:0] o_pos_reg;
    logic [KEY_W-1:0] o_key_reg;
    logic             o_kind_reg;
    logic [VAL_W-1:0] o_value_reg;
    logic             o_last_reg;

    logic [OP_W-1:0]  in_op;
    logic             accept;
    logic [CNT_W-1:0] idx_m1;
    logic             key_ge, key_eq, at_end, scan_stop, shift_more, full, report;
    logic             emit_now, hold, taken;
    logic             mem_re, mem_we;
    logic [AW-1:0]    mem_raddr, mem_waddr;
    entry_t           mem_wdata;

    assign ctl      = ucode(pc_reg);
    assign in_op    = s_tdata[OP_W-1:0];
    assign s_tready = (ctl.uop == U_ACCEPT);
    assign accept   = s_tvalid && s_tready;

    assign idx_m1     = idx_reg - ONE;
    assign key_ge     = chk_reg && (rd_reg.key >= key_reg);
    assign key_eq     = chk_reg && (rd_reg.key == key_reg);
    assign at_end     = (idx_reg == cnt_reg);
    assign scan_stop  = key_ge || at_end;
    assign shift_more = (idx_reg > pos_reg);
    assign full       = (cnt_reg == CNT_CAP);
    assign report     = (op_reg == OP_LOOKUP) || hit_reg || full;

    // A step that wants to emit waits while the output register holds a result that the receiver does not take.
    assign emit_now = (ctl.emit == EM_RES) || (ctl.emit == EM_EMPTY) ||
                      ((ctl.emit == EM_LIST) && chk_reg);
    assign hold     = emit_now && m_tvalid_reg && !m_tready;

    // Next step
    always_comb begin
        taken = 1'b0;
        unique case (ctl.cond)
            C_NEXT:       taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_DISPATCH:   taken = 1'b0;
            C_SCAN_MORE:  taken = !scan_stop;
            C_REPORT:     taken = report;
            C_SHIFT_MORE: taken = shift_more;
            C_EMPTY:      taken = (cnt_reg == '0);
            C_DUMP_MORE:  taken = !(chk_reg && at_end);
            default:      taken = 1'b0;
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        if (!hold) begin
            if (ctl.cond == C_DISPATCH) begin
                if (s_tvalid) begin
                    unique case (in_op) inside
                        OP_INSERT, OP_LOOKUP: pc_next = S_SCAN;
                        OP_DUMP:              pc_next = S_DUMP_CHK;
                        default:              pc_next = S_IDLE;
                    endcase
                end
            end else if (taken) begin
                pc_next = ctl.target;
            end else begin
                pc_next = step_t'(pc_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // Memory port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = idx_reg[AW-1:0];
        if (!hold) begin
            unique case (ctl.uop)
                U_SCAN:  mem_re = !scan_stop;
                U_SHIFT: begin
                    mem_re    = shift_more;
                    mem_raddr = idx_m1[AW-1:0];
                end
                U_DUMP:  mem_re = !at_end;
                default: mem_re = 1'b0;
            endcase
        end
    end

    // A moved entry is written in the cycle after its read; the new entry goes
    // in only after the last move has drained.
    always_comb begin
        if (pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = rd_reg;
        end else begin
            mem_we    = (ctl.uop == U_WNEW);
            mem_waddr = pos_reg[AW-1:0];
            mem_wdata = '{key: key_reg, kind: kind_reg, value: value_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= entry_mem[mem_raddr];
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            chk_reg  <= 1'b0;
        end else begin
            pend_reg <= !hold && (ctl.uop == U_SHIFT) && shift_more;
            if (!hold) begin
                unique case (ctl.uop)
                    U_ACCEPT: begin
                        if (accept) begin
                            op_reg    <= in_op;
                            key_reg   <= s_tdata[OP_W +: KEY_W];
                            value_reg <= s_tdata[OP_W + KEY_W +: VAL_W];
                            kind_reg  <= s_tuser;
                            idx_reg   <= '0;
                            chk_reg   <= 1'b0;
                        end
                    end
                    U_SCAN: begin
                        if (scan_stop) begin
                            pos_reg <= idx_reg - CNT_W'(key_ge);
                            hit_reg <= key_eq;
                        end else begin
                            idx_reg <= idx_reg + ONE;
                            chk_reg <= 1'b1;
                        end
                    end
                    U_RESOLVE: begin
                        idx_reg <= cnt_reg;
                        if (op_reg == OP_LOOKUP) begin
                            status_reg <= hit_reg ? ST_FOUND : ST_NOT_FOUND;
                        end else if (hit_reg) begin
                            status_reg <= ST_DUPLICATE;
                        end else if (full) begin
                            status_reg <= ST_FULL;
                        end else begin
                            status_reg <= ST_INSERTED;
                        end
                    end
                    U_SHIFT: begin
                        if (shift_more) begin
                            wr_addr_reg <= idx_reg[AW-1:0];
                            idx_reg     <= idx_m1;
                        end
                    end
                    U_WNEW: begin
                        cnt_reg <= cnt_reg + ONE;
                    end
                    U_DUMP: begin
                        chk_reg <= 1'b1;
                        if (!at_end) begin
                            idx_reg <= idx_reg + ONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_now && !hold) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_now && !hold) begin
            case (ctl.emit)
                EM_LIST: begin
                    o_status_reg <= ST_LISTED;
                    o_pos_reg    <= POS_W'(idx_m1);
                    o_key_reg    <= rd_reg.key;
                    o_kind_reg   <= rd_reg.kind;
                    o_value_reg  <= rd_reg.value;
                    o_last_reg   <= at_end;
                end
                EM_RES: begin
                    o_status_reg <= status_reg;
                    o_last_reg   <= 1'b1;
                    case (status_reg) inside
                        ST_DUPLICATE, ST_FOUND: begin
                            o_pos_reg   <= POS_W'(pos_reg);
                            o_key_reg   <= rd_reg.key;
                            o_kind_reg  <= rd_reg.kind;
                            o_value_reg <= rd_reg.value;
                        end
                        ST_INSERTED: begin
                            o_pos_reg   <= POS_W'(pos_reg);
                            o_key_reg   <= key_reg;
                            o_kind_reg  <= kind_reg;
                            o_value_reg <= value_reg;
                        end
                        default: begin
                            o_pos_reg   <= POS_W'(cnt_reg);
                            o_key_reg   <= key_reg;
                            o_kind_reg  <= 1'b0;
                            o_value_reg <= '0;
                        end
                    endcase
                end
                default: begin
                    o_status_reg <= ST_EMPTY;
                    o_pos_reg    <= '0;
                    o_key_reg    <= '0;
                    o_kind_reg   <= 1'b0;
                    o_value_reg  <= '0;
                    o_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W - M_FIELDS_W)'(0), o_value_reg, o_key_reg,
                       o_pos_reg, o_status_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

/* design/skt_checker.sv */
// ----------------------------------------------------------------------------
// skt_checker: port-level checks for the sorted key table
// Watches the request and result streams of the top level over time.
// ----------------------------------------------------------------------------
module skt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [skt_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [skt_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import skt_pkg::*;

    // A result offered to a stalled receiver stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Reset drops any pending result.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // A real request keeps the table busy for at least the next cycle.
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        ((s_tdata[OP_W-1:0] == OP_INSERT) || (s_tdata[OP_W-1:0] == OP_LOOKUP) ||
         (s_tdata[OP_W-1:0] == OP_DUMP)) |=> !s_tready)
        else $error("second request taken right after a real one");

    // Only dump results can be non-final.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ST_W-1:0] != ST_LISTED) |-> m_tlast)
        else $error("non-dump result without last");

endmodule

bind sorted_key_table_insert_lookup_unit skt_checker u_skt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
